/* hw/rtl/gpc_pkg.sv */
// ----------------------------------------------------------------------------
// gpc_pkg: shared definitions for the gpio pin controller
// Field widths, register codes, operation codes and the decoded control beat.
// ----------------------------------------------------------------------------
package gpc_pkg;

    localparam int NUM_PINS_DEF         = 54;
    localparam int PINS_PER_SELECT_WORD = 10;
    localparam int PIN_FIELD_W          = 54;
    localparam int DATA_W               = 32;
    localparam int PAD_W                = 64;
    localparam int FSEL_FIELD_W         = 3;
    localparam int PULL_FIELD_W         = 2;
    localparam int PINS_PER_PULL_WORD   = 16;
    localparam int OP_W                 = 2;
    localparam int REG_W                = 4;
    localparam int BANK_W               = 3;

    localparam logic [FSEL_FIELD_W-1:0] FSEL_OUTPUT = 3'b001;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef enum logic [REG_W-1:0] {
        REG_FSEL       = 4'd0,
        REG_SET        = 4'd1,
        REG_CLR        = 4'd2,
        REG_LEVEL      = 4'd3,
        REG_EVENT      = 4'd4,
        REG_HIGH_EN    = 4'd5,
        REG_PULL_CTL   = 4'd6,
        REG_PULL_CLK   = 4'd7,
        REG_PULL_STATE = 4'd8
    } t_reg_id;

    typedef struct packed {
        logic              tick;
        logic              rd;
        logic              wr;
        logic              err;
        t_reg_id           reg_id;
        logic [BANK_W-1:0] bank;
    } t_ctrl;

endpackage

/* hw/rtl/gpio_pin_controller_core.sv */
// ----------------------------------------------------------------------------
// gpio_pin_controller_core: general purpose pin controller
// Register bus access and pin sample ticks over a start / strobe command port.
// ----------------------------------------------------------------------------
// A beat is taken at every clock edge where start is high; busy never rises,
// so one beat per cycle is sustained. Each beat gives exactly one result, shown
// on the o_ result ports with o_strobe for a single cycle. The input register
// takes the beat; the register update is applied in the same cycle as the
// result register is loaded, and the result register drives the ports. The
// receiver cannot stall: a result not captured in its strobe cycle is gone.
// pin_drive and pin_output_enable show the state after the beat; read_data is
// zero for writes, ticks, write-only registers and bad accesses, and
// access_error flags a bad register id or bank.
// ----------------------------------------------------------------------------
module gpio_pin_controller_core #(
    parameter int NUM_PINS = gpc_pkg::NUM_PINS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [gpc_pkg::OP_W-1:0]        i_op,
    input  logic [gpc_pkg::REG_W-1:0]       i_reg_id,
    input  logic [gpc_pkg::BANK_W-1:0]      i_bank,
    input  logic [gpc_pkg::DATA_W-1:0]      i_write_data,
    input  logic [gpc_pkg::PIN_FIELD_W-1:0] i_pin_levels,
    output logic                            o_strobe,
    output logic [gpc_pkg::DATA_W-1:0]      o_read_data,
    output logic [gpc_pkg::PIN_FIELD_W-1:0] o_pin_drive,
    output logic [gpc_pkg::PIN_FIELD_W-1:0] o_pin_output_enable,
    output logic                            o_access_error
);

    // input register
    logic                            r_in_valid;
    logic [gpc_pkg::OP_W-1:0]        r_op;
    logic [gpc_pkg::REG_W-1:0]       r_reg_id;
    logic [gpc_pkg::BANK_W-1:0]      r_bank;
    logic [gpc_pkg::DATA_W-1:0]      r_write_data;
    logic [gpc_pkg::PIN_FIELD_W-1:0] r_pin_levels;

    // result register
    logic                            r_out_valid;
    logic [gpc_pkg::DATA_W-1:0]      r_read_data;
    logic [gpc_pkg::PIN_FIELD_W-1:0] r_pin_drive;
    logic [gpc_pkg::PIN_FIELD_W-1:0] r_pin_oe;
    logic                            r_access_error;

    gpc_pkg::t_ctrl                  ctrl;
    logic [gpc_pkg::DATA_W-1:0]      rd_data;
    logic [gpc_pkg::PIN_FIELD_W-1:0] drive;
    logic [gpc_pkg::PIN_FIELD_W-1:0] oe;
    logic                            accept;

    // every cycle can take a beat
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    // payload holds no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= i_op;
            r_reg_id     <= i_reg_id;
            r_bank       <= i_bank;
            r_write_data <= i_write_data;
            r_pin_levels <= i_pin_levels;
        end
    end

    gpc_decode #(
        .NUM_PINS (NUM_PINS)
    ) u_decode (
        .i_op     (r_op),
        .i_reg_id (r_reg_id),
        .i_bank   (r_bank),
        .o_ctrl   (ctrl)
    );

    gpc_regs #(
        .NUM_PINS (NUM_PINS)
    ) u_regs (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (r_in_valid),
        .i_ctrl              (ctrl),
        .i_write_data        (r_write_data),
        .i_pin_levels        (r_pin_levels),
        .o_read_data         (rd_data),
        .o_pin_drive         (drive),
        .o_pin_output_enable (oe)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_read_data    <= rd_data;
            r_pin_drive    <= drive;
            r_pin_oe       <= oe;
            r_access_error <= ctrl.err;
        end
    end

    assign o_strobe            = r_out_valid;
    assign o_read_data         = r_read_data;
    assign o_pin_drive         = r_pin_drive;
    assign o_pin_output_enable = r_pin_oe;
    assign o_access_error      = r_access_error;

endmodule

/* hw/rtl/gpc_decode.sv */
// ----------------------------------------------------------------------------
// gpc_decode: access decode
// Classifies the beat and checks the register id and bank against the layout.
// ----------------------------------------------------------------------------
module gpc_decode #(
    parameter int NUM_PINS = gpc_pkg::NUM_PINS_DEF
) (
    input  logic [gpc_pkg::OP_W-1:0]   i_op,
    input  logic [gpc_pkg::REG_W-1:0]  i_reg_id,
    input  logic [gpc_pkg::BANK_W-1:0] i_bank,
    output gpc_pkg::t_ctrl             o_ctrl
);

    localparam int FselWords = (NUM_PINS + gpc_pkg::PINS_PER_SELECT_WORD - 1)
                               / gpc_pkg::PINS_PER_SELECT_WORD;
    localparam int BitWords  = (NUM_PINS + gpc_pkg::DATA_W - 1) / gpc_pkg::DATA_W;
    localparam int PullWords = (NUM_PINS + gpc_pkg::PINS_PER_PULL_WORD - 1)
                               / gpc_pkg::PINS_PER_PULL_WORD;
    localparam int LimW      = gpc_pkg::BANK_W + 1;

    logic [LimW-1:0] limit;
    logic            access;

    always_comb begin
        unique case (gpc_pkg::t_reg_id'(i_reg_id))
            gpc_pkg::REG_FSEL:       limit = LimW'(FselWords);
            gpc_pkg::REG_SET,
            gpc_pkg::REG_CLR,
            gpc_pkg::REG_LEVEL,
            gpc_pkg::REG_EVENT,
            gpc_pkg::REG_HIGH_EN,
            gpc_pkg::REG_PULL_CLK:   limit = LimW'(BitWords);
            gpc_pkg::REG_PULL_CTL:   limit = LimW'(1);
            gpc_pkg::REG_PULL_STATE: limit = LimW'(PullWords);
            default:                 limit = '0;
        endcase
    end

    assign access        = (i_op == gpc_pkg::OP_READ) || (i_op == gpc_pkg::OP_WRITE);
    assign o_ctrl.tick   = (i_op == gpc_pkg::OP_TICK);
    assign o_ctrl.err    = access && ({1'b0, i_bank} >= limit);
    assign o_ctrl.rd     = (i_op == gpc_pkg::OP_READ) && !o_ctrl.err;
    assign o_ctrl.wr     = (i_op == gpc_pkg::OP_WRITE) && !o_ctrl.err;
    assign o_ctrl.reg_id = gpc_pkg::t_reg_id'(i_reg_id);
    assign o_ctrl.bank   = i_bank;

endmodule

/* hw/rtl/gpc_regs.sv */
// ----------------------------------------------------------------------------
// gpc_regs: pin state registers
// Holds the per-pin state, applies one decoded beat and forms the readback.
// ----------------------------------------------------------------------------
module gpc_regs #(
    parameter int NUM_PINS = gpc_pkg::NUM_PINS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  gpc_pkg::t_ctrl                  i_ctrl,
    input  logic [gpc_pkg::DATA_W-1:0]      i_write_data,
    input  logic [gpc_pkg::PIN_FIELD_W-1:0] i_pin_levels,
    output logic [gpc_pkg::DATA_W-1:0]      o_read_data,
    output logic [gpc_pkg::PIN_FIELD_W-1:0] o_pin_drive,
    output logic [gpc_pkg::PIN_FIELD_W-1:0] o_pin_output_enable
);

    localparam int PinsW     = gpc_pkg::PINS_PER_SELECT_WORD;
    localparam int FselWords = (NUM_PINS + PinsW - 1) / PinsW;
    localparam int FselWordW = PinsW * gpc_pkg::FSEL_FIELD_W;
    localparam int PullWords = (NUM_PINS + gpc_pkg::PINS_PER_PULL_WORD - 1)
                               / gpc_pkg::PINS_PER_PULL_WORD;
    localparam int DW        = gpc_pkg::DATA_W;
    localparam int FW        = gpc_pkg::FSEL_FIELD_W;
    localparam int PW        = gpc_pkg::PULL_FIELD_W;

    logic [FW*NUM_PINS-1:0] r_fsel,      n_fsel;
    logic [NUM_PINS-1:0]    r_latch,     n_latch;
    logic [NUM_PINS-1:0]    r_level,     n_level;
    logic [NUM_PINS-1:0]    r_high_en,   n_high_en;
    logic [NUM_PINS-1:0]    r_event,     n_event;
    logic [PW-1:0]          r_pull_ctl,  n_pull_ctl;
    logic [NUM_PINS-1:0]    r_pull_clk,  n_pull_clk;
    logic [PW*NUM_PINS-1:0] r_pull_st,   n_pull_st;

    logic [FselWords*FselWordW-1:0] fsel_pad;
    logic [PullWords*DW-1:0]        pull_pad;
    logic [gpc_pkg::PAD_W-1:0]      spread64;
    logic [gpc_pkg::PAD_W-1:0]      mask64;
    logic [gpc_pkg::PAD_W-1:0]      levels64;
    logic [gpc_pkg::PAD_W-1:0]      drive64;
    logic [gpc_pkg::PAD_W-1:0]      oe64;
    logic [NUM_PINS-1:0]            spread_v;
    logic [NUM_PINS-1:0]            mask_v;
    logic [NUM_PINS-1:0]            rise;
    logic [NUM_PINS-1:0]            oe_v;
    logic [gpc_pkg::PAD_W-1:0]      rd_vec;

    // word placement of the data beat onto the pin vectors
    always_comb begin
        spread64 = i_ctrl.bank[0] ? {i_write_data, {DW{1'b0}}} : {{DW{1'b0}}, i_write_data};
        mask64   = i_ctrl.bank[0] ? {{DW{1'b1}}, {DW{1'b0}}} : {{DW{1'b0}}, {DW{1'b1}}};
        levels64 = '0;
        levels64[gpc_pkg::PIN_FIELD_W-1:0] = i_pin_levels;
    end

    assign spread_v = spread64[NUM_PINS-1:0];
    assign mask_v   = mask64[NUM_PINS-1:0];

    // readback, from the state before the beat
    always_comb begin
        fsel_pad = '0;
        fsel_pad[FW*NUM_PINS-1:0] = r_fsel;
        pull_pad = '0;
        pull_pad[PW*NUM_PINS-1:0] = r_pull_st;
        rd_vec   = '0;
        o_read_data = '0;
        if (i_ctrl.rd) begin
            unique case (i_ctrl.reg_id)
                gpc_pkg::REG_FSEL: begin
                    o_read_data = DW'(fsel_pad[i_ctrl.bank * FselWordW +: FselWordW]);
                end
                gpc_pkg::REG_LEVEL:    rd_vec[NUM_PINS-1:0] = r_level;
                gpc_pkg::REG_EVENT:    rd_vec[NUM_PINS-1:0] = r_event;
                gpc_pkg::REG_HIGH_EN:  rd_vec[NUM_PINS-1:0] = r_high_en;
                gpc_pkg::REG_PULL_CLK: rd_vec[NUM_PINS-1:0] = r_pull_clk;
                gpc_pkg::REG_PULL_CTL: o_read_data = DW'(r_pull_ctl);
                gpc_pkg::REG_PULL_STATE: begin
                    o_read_data = pull_pad[i_ctrl.bank * DW +: DW];
                end
                default: o_read_data = '0;
            endcase
            if ((i_ctrl.reg_id == gpc_pkg::REG_LEVEL) || (i_ctrl.reg_id == gpc_pkg::REG_EVENT)
                || (i_ctrl.reg_id == gpc_pkg::REG_HIGH_EN)
                || (i_ctrl.reg_id == gpc_pkg::REG_PULL_CLK)) begin
                o_read_data = i_ctrl.bank[0] ? rd_vec[2*DW-1:DW] : rd_vec[DW-1:0];
            end
        end
    end

    // state update for one beat
    always_comb begin
        n_fsel     = r_fsel;
        n_latch    = r_latch;
        n_level    = r_level;
        n_high_en  = r_high_en;
        n_event    = r_event;
        n_pull_ctl = r_pull_ctl;
        n_pull_clk = r_pull_clk;
        n_pull_st  = r_pull_st;
        rise       = '0;
        if (i_en && i_ctrl.tick) begin
            n_level = levels64[NUM_PINS-1:0];
            n_event = r_event | (levels64[NUM_PINS-1:0] & r_high_en);
        end else if (i_en && i_ctrl.wr) begin
            unique case (i_ctrl.reg_id)
                gpc_pkg::REG_FSEL: begin
                    for (int i = 0; i < NUM_PINS; i++) begin
                        if ((i / PinsW) == int'(i_ctrl.bank)) begin
                            n_fsel[FW*i +: FW] = i_write_data[FW*(i % PinsW) +: FW];
                        end
                    end
                end
                gpc_pkg::REG_SET:     n_latch   = r_latch | spread_v;
                gpc_pkg::REG_CLR:     n_latch   = r_latch & ~spread_v;
                gpc_pkg::REG_EVENT:   n_event   = r_event & ~spread_v;
                gpc_pkg::REG_HIGH_EN: n_high_en = (r_high_en & ~mask_v) | spread_v;
                gpc_pkg::REG_PULL_CTL: n_pull_ctl = i_write_data[PW-1:0];
                gpc_pkg::REG_PULL_CLK: begin
                    n_pull_clk = (r_pull_clk & ~mask_v) | spread_v;
                    rise       = n_pull_clk & ~r_pull_clk;
                    for (int i = 0; i < NUM_PINS; i++) begin
                        if (rise[i]) begin
                            n_pull_st[PW*i +: PW] = r_pull_ctl;
                        end
                    end
                end
                default: n_latch = r_latch;
            endcase
        end
    end

    // pin outputs after the update
    always_comb begin
        for (int i = 0; i < NUM_PINS; i++) begin
            oe_v[i] = (n_fsel[FW*i +: FW] == gpc_pkg::FSEL_OUTPUT);
        end
        drive64 = '0;
        drive64[NUM_PINS-1:0] = n_latch;
        oe64 = '0;
        oe64[NUM_PINS-1:0] = oe_v;
    end

    assign o_pin_drive         = drive64[gpc_pkg::PIN_FIELD_W-1:0];
    assign o_pin_output_enable = oe64[gpc_pkg::PIN_FIELD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsel     <= '0;
            r_latch    <= '0;
            r_level    <= '0;
            r_high_en  <= '0;
            r_event    <= '0;
            r_pull_ctl <= '0;
            r_pull_clk <= '0;
            r_pull_st  <= '0;
        end else begin
            r_fsel     <= n_fsel;
            r_latch    <= n_latch;
            r_level    <= n_level;
            r_high_en  <= n_high_en;
            r_event    <= n_event;
            r_pull_ctl <= n_pull_ctl;
            r_pull_clk <= n_pull_clk;
            r_pull_st  <= n_pull_st;
        end
    end

endmodule
